// ===== sv/wsmd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsmd_pkg
// Shared constants, types and codes of the weighted sorted merge with
// decimation: list sizes, register indexes, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package wsmd_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int FILL_W     = $clog2(LIST_DEPTH + 1);
  localparam int VALUE_W    = 64;
  localparam int WEIGHT_W   = 16;
  localparam int TOTAL_W    = WEIGHT_W + 1;
  localparam int SUM_W      = WEIGHT_W + 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_WT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_WT = 1'b1;

  localparam logic SIDE_LEFT  = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PICK,
    ST_FLUSH
  } wsmd_state_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic pick;
    logic flush;
  } wsmd_cmd_t;

  typedef struct packed {
    logic left_more;
    logic right_more;
  } wsmd_status_t;

endpackage

// ===== sv/weighted_sorted_merge_decimate.sv =====
// ----------------------------------------------------------------------------
// weighted_sorted_merge_decimate
// Loads two ascending lists of signed values, then merges them and emits
// one value for every step of the weighted count divided by the total weight.
// ----------------------------------------------------------------------------
// Busy stays low during a load beat and a new beat may follow at once.
// The end-of-load beat starts a merge: a fetch and a pick per stored element
// (one memory read port per list), then a last fetch and a flush.
// Results appear in the cycle after the pick that confirms them; the last one in the
// cycle after the flush, when busy is already low.
// The receiver cannot stall; each result is valid for the one cycle that result_strobe is high.
// Synchronous reset empties both lists and sets both weights to one.
module weighted_sorted_merge_decimate (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                side,
  input  logic                                carries_value,
  input  logic signed [wsmd_pkg::VALUE_W-1:0] sample_value,
  input  logic                                end_of_load,
  input  logic                                cfg_write,
  input  logic [wsmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsmd_pkg::WEIGHT_W-1:0]       cfg_data,
  output logic                                result_strobe,
  output logic signed [wsmd_pkg::VALUE_W-1:0] merged_value,
  output logic                                last
);
  import wsmd_pkg::*;

  wsmd_cmd_t    cmd;
  wsmd_status_t status;

  wsmd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .end_of_load (end_of_load),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy)
  );

  wsmd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .side          (side),
    .carries_value (carries_value),
    .sample_value  (sample_value),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .merged_value  (merged_value),
    .last          (last)
  );

endmodule

// ===== sv/wsmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsmd_ctrl
// Controller of the merge: accepts load beats while idle, then steps the
// datapath through fetch and pick cycles for every stored element and ends
// with a flush cycle that delivers the final result.
// ----------------------------------------------------------------------------
module wsmd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  end_of_load,
  input  wsmd_pkg::wsmd_status_t status,
  output wsmd_pkg::wsmd_cmd_t    cmd,
  output logic                  busy
);
  import wsmd_pkg::*;

  wsmd_state_t state;
  wsmd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && end_of_load) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (status.left_more || status.right_more) begin
          state_next = ST_PICK;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_PICK: begin
        state_next = ST_FETCH;
      end
      ST_FLUSH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/wsmd_datapath.sv =====
// ----------------------------------------------------------------------------
// wsmd_datapath
// Weight registers, the two list memories with their fill counts and read
// indexes, the signed head compare, the running remainder of the weighted
// count and the output register with a one-result hold for the last flag.
// ----------------------------------------------------------------------------
module wsmd_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  wsmd_pkg::wsmd_cmd_t               cmd,
  output wsmd_pkg::wsmd_status_t            status,
  input  logic                             side,
  input  logic                             carries_value,
  input  logic signed [wsmd_pkg::VALUE_W-1:0] sample_value,
  input  logic                             cfg_write,
  input  logic [wsmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wsmd_pkg::WEIGHT_W-1:0]    cfg_data,
  output logic                             result_strobe,
  output logic signed [wsmd_pkg::VALUE_W-1:0] merged_value,
  output logic                             last
);
  import wsmd_pkg::*;

  logic [WEIGHT_W-1:0] left_wt;
  logic [WEIGHT_W-1:0] right_wt;

  logic [VALUE_W-1:0] left_mem  [LIST_DEPTH];
  logic [VALUE_W-1:0] right_mem [LIST_DEPTH];
  logic [VALUE_W-1:0] left_head;
  logic [VALUE_W-1:0] right_head;

  logic [FILL_W-1:0] left_fill;
  logic [FILL_W-1:0] right_fill;
  logic [FILL_W-1:0] left_idx;
  logic [FILL_W-1:0] right_idx;

  logic [TOTAL_W-1:0] remainder;
  logic [VALUE_W-1:0] pending;
  logic               pending_valid;

  logic [WEIGHT_W-1:0] left_eff;
  logic [WEIGHT_W-1:0] right_eff;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  bias;
  logic                take_left;
  logic [VALUE_W-1:0]  pick_value;
  logic [WEIGHT_W-1:0] pick_weight;
  logic [SUM_W-1:0]    sum;
  logic                emit;
  logic                store_left;
  logic                store_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_wt  <= WEIGHT_W'(1);
      right_wt <= WEIGHT_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEFT_WT:  left_wt  <= cfg_data;
        REG_RIGHT_WT: right_wt <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A zero weight counts as one.
  assign left_eff  = (left_wt == '0) ? WEIGHT_W'(1) : left_wt;
  assign right_eff = (right_wt == '0) ? WEIGHT_W'(1) : right_wt;
  assign total     = {1'b0, left_eff} + {1'b0, right_eff};
  assign bias      = (total >> 1) - TOTAL_W'(1);

  assign status.left_more  = left_idx < left_fill;
  assign status.right_more = right_idx < right_fill;

  assign store_left  = cmd.load && carries_value && (side == SIDE_LEFT) &&
                       (left_fill < FILL_W'(LIST_DEPTH));
  assign store_right = cmd.load && carries_value && (side != SIDE_LEFT) &&
                       (right_fill < FILL_W'(LIST_DEPTH));

  always_ff @(posedge clk) begin
    if (store_left) begin
      left_mem[left_fill[ADDR_W-1:0]] <= sample_value;
    end
    if (store_right) begin
      right_mem[right_fill[ADDR_W-1:0]] <= sample_value;
    end
    if (cmd.fetch) begin
      left_head  <= left_mem[left_idx[ADDR_W-1:0]];
      right_head <= right_mem[right_idx[ADDR_W-1:0]];
    end
  end

  // Ties go to the right list.
  assign take_left   = status.left_more &&
                       (!status.right_more || ($signed(left_head) < $signed(right_head)));
  assign pick_value  = take_left ? left_head : right_head;
  assign pick_weight = take_left ? left_eff : right_eff;
  assign sum         = {1'b0, remainder} + {2'b00, pick_weight};
  assign emit        = sum >= {1'b0, total};

  always_ff @(posedge clk) begin
    if (rst) begin
      left_fill     <= '0;
      right_fill    <= '0;
      left_idx      <= '0;
      right_idx     <= '0;
      pending_valid <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= pending_valid && ((cmd.pick && emit) || cmd.flush);
      if (cmd.load) begin
        left_idx      <= '0;
        right_idx     <= '0;
        remainder     <= bias;
        pending_valid <= 1'b0;
        if (store_left) begin
          left_fill <= left_fill + FILL_W'(1);
        end
        if (store_right) begin
          right_fill <= right_fill + FILL_W'(1);
        end
      end
      if (cmd.pick) begin
        if (take_left) begin
          left_idx <= left_idx + FILL_W'(1);
        end else begin
          right_idx <= right_idx + FILL_W'(1);
        end
        if (emit) begin
          remainder     <= TOTAL_W'(sum - {1'b0, total});
          pending       <= pick_value;
          pending_valid <= 1'b1;
          if (pending_valid) begin
            merged_value  <= pending;
            last          <= 1'b0;
          end
        end else begin
          remainder <= TOTAL_W'(sum);
        end
      end
      if (cmd.flush) begin
        left_fill     <= '0;
        right_fill    <= '0;
        pending_valid <= 1'b0;
        if (pending_valid) begin
          merged_value  <= pending;
          last          <= 1'b1;
        end
      end
    end
  end

endmodule
